// File: hw/rtl/ipm_pkg.sv
package ipm_pkg;

   localparam int TERM_BITS_DEF = 8;
   localparam int MAX_TERMS_DEF = 32;

   typedef struct packed {
      logic load;
      logic scan;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic held_vld;
      logic out_free;
   } sts_type;

endpackage

// File: hw/rtl/implicant_pair_merger_unit.sv
// A minterm holds the block until the scan of the terms stored before it ends and any held result
// has gone to the output register; the term memory is read one entry a cycle while no result
// back-pressure stalls the scan.
// Reset (synchronous, active high) empties the set and the result register; the term
// memory itself is not cleared.
module implicant_pair_merger_unit #(
   parameter int TERM_BITS = ipm_pkg::TERM_BITS_DEF,
   parameter int MAX_TERMS = ipm_pkg::MAX_TERMS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic                                                req_tvalid,
   output logic                                                req_tready,
   // minterm
   input  logic [((TERM_BITS+7)/8)*8-1:0]                      req_tdata,
   // new_set
   input  logic                                                req_tuser,
   output logic                                                rsp_tvalid,
   input  logic                                                rsp_tready,
   // merged_value, free_bit, earlier_minterm
   output logic [((2*TERM_BITS+$clog2(TERM_BITS)+7)/8)*8-1:0] rsp_tdata,
   // set_full
   output logic                                                rsp_tuser,
   output logic                                                rsp_tlast
);

   import ipm_pkg::*;

   localparam int POS_W = $clog2(TERM_BITS);
   localparam int OUT_W = ((2*TERM_BITS + POS_W + 7) / 8) * 8;

   cmd_type              cmd;
   sts_type              sts;
   logic [TERM_BITS-1:0] merged_value;
   logic [POS_W-1:0]     free_bit;
   logic [TERM_BITS-1:0] earlier_minterm;

   ipm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ipm_datapath #(
      .TERM_BITS (TERM_BITS),
      .MAX_TERMS (MAX_TERMS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_minterm         (req_tdata[TERM_BITS-1:0]),
      .req_new_set         (req_tuser),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_tready          (rsp_tready),
      .rsp_valid           (rsp_tvalid),
      .rsp_merged_value    (merged_value),
      .rsp_free_bit        (free_bit),
      .rsp_earlier_minterm (earlier_minterm),
      .rsp_set_full        (rsp_tuser),
      .rsp_last            (rsp_tlast)
   );

   assign rsp_tdata = OUT_W'({earlier_minterm, free_bit, merged_value});

   a_flush_is_last: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> rsp_tvalid && rsp_tlast)
      else $error("final result of a transaction not presented with tlast");

   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_tready)
      else $error("request taken while a minterm is still being compared");

   a_flush_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> sts.held_vld && sts.out_free)
      else $error("flush without a held result or with the output register occupied");

endmodule

// File: hw/rtl/ipm_ram.sv
module ipm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ipm_ctrl.sv
module ipm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  ipm_pkg::sts_type sts,
   output ipm_pkg::cmd_type cmd
);

   import ipm_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DRAIN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid) begin
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            if (!sts.held_vld) begin
               state_in = IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/ipm_datapath.sv
module ipm_datapath #(
   parameter int TERM_BITS = ipm_pkg::TERM_BITS_DEF,
   parameter int MAX_TERMS = ipm_pkg::MAX_TERMS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [TERM_BITS-1:0]         req_minterm,
   input  logic                         req_new_set,
   input  ipm_pkg::cmd_type             cmd,
   output ipm_pkg::sts_type             sts,
   input  logic                         rsp_tready,
   output logic                         rsp_valid,
   output logic [TERM_BITS-1:0]         rsp_merged_value,
   output logic [$clog2(TERM_BITS)-1:0] rsp_free_bit,
   output logic [TERM_BITS-1:0]         rsp_earlier_minterm,
   output logic                         rsp_set_full,
   output logic                         rsp_last
);

   import ipm_pkg::*;

   localparam int POS_W = $clog2(TERM_BITS);
   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam int IDX_W = $clog2(MAX_TERMS);

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     lim_ff, lim_in;
   logic [CNT_W-1:0]     nxt_ff, nxt_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [TERM_BITS-1:0] term_ff, term_in;
   logic                 full_ff, full_in;

   logic                 held_vld_ff, held_vld_in;
   logic [TERM_BITS-1:0] held_merged_ff, held_merged_in;
   logic [POS_W-1:0]     held_pos_ff, held_pos_in;
   logic [TERM_BITS-1:0] held_earlier_ff, held_earlier_in;

   logic                 rsp_vld_ff, rsp_vld_in;
   logic [TERM_BITS-1:0] rsp_merged_ff, rsp_merged_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [TERM_BITS-1:0] rsp_earlier_ff, rsp_earlier_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]     count_eff;
   logic                 full_eff;
   logic                 wr_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [TERM_BITS-1:0] rd_data;
   logic [TERM_BITS-1:0] diff;
   logic                 one_hot;
   logic [POS_W-1:0]     pos;
   logic                 cap;
   logic                 match_ok;
   logic                 out_free;
   logic                 stall;
   logic                 issue;
   logic                 push;
   logic                 push_last;

   ipm_ram #(
      .WIDTH (TERM_BITS),
      .DEPTH (MAX_TERMS)
   ) u_terms (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_eff[IDX_W-1:0]),
      .wr_data (req_minterm),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_eff = req_new_set ? '0 : count_ff;
      full_eff  = (count_eff == CNT_W'(MAX_TERMS));
      wr_en     = cmd.load && !full_eff;

      diff    = rd_data ^ term_ff;
      one_hot = (diff != '0) && ((diff & (diff - TERM_BITS'(1))) == '0);
      pos     = '0;
      for (int i = 0; i < TERM_BITS; i++) begin
         if (diff[i]) begin
            pos = POS_W'(i);
         end
      end

      cap      = (n_ff == CNT_W'(MAX_TERMS - 1));
      match_ok = cmd.scan && chk_vld_ff && one_hot && !cap;
      out_free = !rsp_vld_ff || rsp_tready;
      stall    = match_ok && held_vld_ff && !out_free;
      issue    = cmd.scan && !stall && !cap && (nxt_ff < lim_ff);
      rd_addr  = stall ? chk_idx_ff : nxt_ff[IDX_W-1:0];

      count_in        = count_ff;
      lim_in          = lim_ff;
      nxt_in          = nxt_ff;
      n_in            = n_ff;
      chk_idx_in      = chk_idx_ff;
      chk_vld_in      = chk_vld_ff;
      term_in         = term_ff;
      full_in         = full_ff;
      held_vld_in     = held_vld_ff;
      held_merged_in  = held_merged_ff;
      held_pos_in     = held_pos_ff;
      held_earlier_in = held_earlier_ff;
      push            = 1'b0;
      push_last       = 1'b0;

      if (cmd.load) begin
         term_in     = req_minterm;
         full_in     = full_eff;
         lim_in      = count_eff;
         count_in    = count_eff + CNT_W'(!full_eff);
         nxt_in      = '0;
         n_in        = '0;
         chk_vld_in  = 1'b0;
         held_vld_in = 1'b0;
      end

      if (cmd.scan && !stall) begin
         chk_vld_in = issue;
         if (issue) begin
            chk_idx_in = nxt_ff[IDX_W-1:0];
            nxt_in     = nxt_ff + CNT_W'(1);
         end
         if (match_ok) begin
            push            = held_vld_ff;
            held_vld_in     = 1'b1;
            held_merged_in  = term_ff & ~diff;
            held_pos_in     = pos;
            held_earlier_in = rd_data;
            n_in            = n_ff + CNT_W'(1);
         end
      end

      if (cmd.flush) begin
         push        = 1'b1;
         push_last   = 1'b1;
         held_vld_in = 1'b0;
      end

      rsp_vld_in     = rsp_vld_ff && !rsp_tready;
      rsp_merged_in  = rsp_merged_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_earlier_in = rsp_earlier_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_last_in    = rsp_last_ff;
      if (push) begin
         rsp_vld_in     = 1'b1;
         rsp_merged_in  = held_merged_ff;
         rsp_pos_in     = held_pos_ff;
         rsp_earlier_in = held_earlier_ff;
         rsp_full_in    = full_ff;
         rsp_last_in    = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         chk_vld_ff  <= 1'b0;
         held_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         chk_vld_ff  <= chk_vld_in;
         held_vld_ff <= held_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      lim_ff          <= lim_in;
      nxt_ff          <= nxt_in;
      n_ff            <= n_in;
      chk_idx_ff      <= chk_idx_in;
      term_ff         <= term_in;
      full_ff         <= full_in;
      held_merged_ff  <= held_merged_in;
      held_pos_ff     <= held_pos_in;
      held_earlier_ff <= held_earlier_in;
      rsp_merged_ff   <= rsp_merged_in;
      rsp_pos_ff      <= rsp_pos_in;
      rsp_earlier_ff  <= rsp_earlier_in;
      rsp_full_ff     <= rsp_full_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign sts.scan_done = !chk_vld_ff && (cap || (nxt_ff >= lim_ff));
   assign sts.held_vld  = held_vld_ff;
   assign sts.out_free  = out_free;

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_merged_value    = rsp_merged_ff;
   assign rsp_free_bit        = rsp_pos_ff;
   assign rsp_earlier_minterm = rsp_earlier_ff;
   assign rsp_set_full        = rsp_full_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
